// ===== rtl/core/cursor_line_editor_defines.svh =====
// Assertion macros for the line editor top level.
`ifndef CURSOR_LINE_EDITOR_DEFINES_SVH
`define CURSOR_LINE_EDITOR_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define CLE_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cursor_line_editor: implication check failed");

// Invariant checked on every rising clock edge outside reset.
`define CLE_ASSERT_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("cursor_line_editor: invariant check failed");

`endif

// ===== rtl/core/cle_pkg.sv =====
// Types, codes and sizes shared by the line editor modules.
package cle_pkg;

   localparam int DEPTH       = 1024;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int PTR_W       = ADDR_W + 1;

   localparam int CMD_W       = 3;
   localparam int CH_W        = 8;
   localparam int POS_W       = 10;
   localparam int LEN_W       = 11;
   localparam int STATUS_W    = 2;

   // Width that holds both a text index and a pointer without overflow.
   localparam int CALC_W      = (PTR_W > POS_W + 1) ? PTR_W : POS_W + 1;

   localparam int QUEUE_DEPTH = 2;

   localparam int REQ_TDATA_W = 24;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 32;
   localparam int RSP_TUSER_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 3'd0,
      CMD_LEFT   = 3'd1,
      CMD_RIGHT  = 3'd2,
      CMD_BACK   = 3'd3,
      CMD_READ   = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      OP_INSERT,
      OP_LEFT,
      OP_RIGHT,
      OP_BACK,
      OP_READ,
      OP_IGNORE
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EDGE  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      BK_EXEC,
      BK_MOVE,
      BK_READ
   } back_state_type;

   typedef struct packed {
      op_type            op;
      logic [CH_W-1:0]   ch;
      logic [POS_W-1:0]  pos;
   } op_word_type;

   typedef struct packed {
      logic [CH_W-1:0]   read_char;
      logic [LEN_W-1:0]  text_length;
      logic [LEN_W-1:0]  cursor_pos;
      status_type        status;
   } result_type;

endpackage

// ===== rtl/core/cursor_line_editor.sv =====
// Top level of the gap-buffer line editor: ports, word packing and checks.
//
// Each request word carries one command: insert a byte before the cursor, move
// the cursor left or right, delete the byte left of the cursor, or read the
// byte at a text index. Every request gives exactly one response word with the
// text length, the cursor position, a status and, for a read, the byte.
// A front end classifies commands into a two-entry queue; the back end owns the
// single-port text RAM and the gap pointers.
// Insert, backspace and edge or range rejections pass through the queue and the
// response register; cursor moves and good reads add a BK_MOVE or BK_READ state.
// The back end takes one short command per cycle while the receiver does not
// stall; a move or read holds it in that extra state, since it needs a read and
// then a write or a data capture on the one RAM port.
// Reset clears the pointers to an empty text with the cursor at the start and
// empties the queue; the RAM contents are not cleared and need no sweep.
// When the receiver stalls, the response register holds its word, the queue
// fills, and req_tready drops once both queue entries are taken.
`include "cursor_line_editor_defines.svh"

module cursor_line_editor (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // ch [7:0], position [17:8], zero [23:18]
   input  logic [cle_pkg::REQ_TDATA_W-1:0] req_tdata,
   // cmd [2:0]
   input  logic [cle_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // read_char [7:0], text_length [18:8], cursor_pos [29:19], zero [31:30]
   output logic [cle_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // status [1:0]
   output logic [cle_pkg::RSP_TUSER_W-1:0] rsp_tuser
);
   import cle_pkg::*;

   localparam int RSP_PAD_W = RSP_TDATA_W - CH_W - 2 * LEN_W;

   logic        push_valid, push_ready, pop_valid, pop_ready;
   op_word_type push_word, pop_word;
   result_type  rsp_res;

   cle_front u_front (
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_cmd    (req_tuser[CMD_W-1:0]),
      .req_ch     (req_tdata[CH_W-1:0]),
      .req_pos    (req_tdata[CH_W+POS_W-1:CH_W]),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_word  (push_word)
   );

   cle_fifo u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_word  (push_word),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_word   (pop_word)
   );

   cle_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_word   (pop_word),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (rsp_res)
   );

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp_res.cursor_pos, rsp_res.text_length,
                       rsp_res.read_char};
   assign rsp_tuser = rsp_res.status;

   // The cursor can never sit beyond the end of the text.
   `CLE_ASSERT_ALWAYS(a_cursor_in_text, !rsp_tvalid || (rsp_res.cursor_pos <= rsp_res.text_length))
   // A dropped insert only happens when the buffer is completely full.
   `CLE_ASSERT_IMP(a_full_at_depth, rsp_tvalid && (rsp_res.status == ST_FULL), rsp_res.text_length == LEN_W'(DEPTH))
   // Only a successful read returns a non-zero byte.
   `CLE_ASSERT_IMP(a_char_only_on_done, rsp_tvalid && (rsp_res.read_char != '0), rsp_res.status == ST_DONE)

endmodule

// ===== rtl/core/cle_ram.sv =====
// Generic single-port RAM with a registered read.
module cle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/cle_front.sv =====
// Front end: takes request words and classifies each command into an operation.
module cle_front (
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [cle_pkg::CMD_W-1:0] req_cmd,
   input  logic [cle_pkg::CH_W-1:0]  req_ch,
   input  logic [cle_pkg::POS_W-1:0] req_pos,
   output logic                      push_valid,
   input  logic                      push_ready,
   output cle_pkg::op_word_type      push_word
);
   import cle_pkg::*;

   op_type op_kind;

   always_comb begin
      case (cmd_type'(req_cmd))
         CMD_INSERT: op_kind = OP_INSERT;
         CMD_LEFT:   op_kind = OP_LEFT;
         CMD_RIGHT:  op_kind = OP_RIGHT;
         CMD_BACK:   op_kind = OP_BACK;
         CMD_READ:   op_kind = OP_READ;
         default:    op_kind = OP_IGNORE;
      endcase
   end

   assign push_valid     = req_valid;
   assign req_ready      = push_ready;
   assign push_word.op   = op_kind;
   assign push_word.ch   = req_ch;
   assign push_word.pos  = req_pos;

endmodule

// ===== rtl/core/cle_fifo.sv =====
// Short queue of classified operations between the front and back ends.
module cle_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  cle_pkg::op_word_type push_word,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output cle_pkg::op_word_type pop_word
);
   import cle_pkg::*;

   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   op_word_type       entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff,  count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_word   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ===== rtl/core/cle_back.sv =====
// Back end: runs operations on the gap buffer and holds the result word.
module cle_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  cle_pkg::op_word_type pop_word,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output cle_pkg::result_type  rsp_result
);
   import cle_pkg::*;

   back_state_type    state_ff, state_in;
   logic [PTR_W-1:0]  gs_ff, gs_in;
   logic [PTR_W-1:0]  ge_ff, ge_in;
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        res_ff, res_in;
   logic              res_load;

   logic              ram_en, ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [CH_W-1:0]   ram_wdata, ram_rdata;

   logic              out_free, launch;
   logic              full, left_ok, right_ok, read_ok;
   logic [PTR_W-1:0]  gs_dec, ge_dec, gs_inc, ge_inc;
   logic [CALC_W-1:0] len_now, len_next, pos_w, read_idx;

   cle_ram #(.WIDTH(CH_W), .DEPTH(DEPTH)) u_text_ram (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign launch   = (state_ff == BK_EXEC) && pop_valid && out_free;
   assign pop_ready = launch;

   assign gs_dec = gs_ff - PTR_W'(1);
   assign ge_dec = ge_ff - PTR_W'(1);
   assign gs_inc = gs_ff + PTR_W'(1);
   assign ge_inc = ge_ff + PTR_W'(1);

   assign len_now  = CALC_W'(gs_ff) + CALC_W'(DEPTH) - CALC_W'(ge_ff);
   assign len_next = CALC_W'(gs_in) + CALC_W'(DEPTH) - CALC_W'(ge_in);
   assign pos_w    = CALC_W'(pop_word.pos);
   // Indexes past the cursor skip over the gap.
   assign read_idx = (pos_w < CALC_W'(gs_ff)) ?
                     pos_w : pos_w + CALC_W'(ge_ff) - CALC_W'(gs_ff);

   assign full     = (gs_ff == ge_ff);
   assign left_ok  = (gs_ff != '0);
   assign right_ok = (ge_ff != PTR_W'(DEPTH));
   assign read_ok  = (pos_w < len_now);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_EXEC: begin
            if (launch) begin
               if ((pop_word.op == OP_LEFT && left_ok) ||
                   (pop_word.op == OP_RIGHT && right_ok)) begin
                  state_in = BK_MOVE;
               end else if (pop_word.op == OP_READ && read_ok) begin
                  state_in = BK_READ;
               end
            end
         end
         BK_MOVE: state_in = BK_EXEC;
         BK_READ: state_in = BK_EXEC;
         default: state_in = BK_EXEC;
      endcase
   end

   always_comb begin
      gs_in      = gs_ff;
      ge_in      = ge_ff;
      wr_addr_in = wr_addr_ff;
      ram_en     = 1'b0;
      ram_we     = 1'b0;
      ram_addr   = gs_ff[ADDR_W-1:0];
      ram_wdata  = pop_word.ch;
      res_load   = 1'b0;
      res_in.read_char = '0;
      res_in.status    = ST_DONE;
      case (state_ff)
         BK_EXEC: begin
            if (launch) begin
               case (pop_word.op)
                  OP_INSERT: begin
                     res_load = 1'b1;
                     if (full) begin
                        res_in.status = ST_FULL;
                     end else begin
                        ram_en = 1'b1;
                        ram_we = 1'b1;
                        gs_in  = gs_inc;
                     end
                  end
                  OP_LEFT: begin
                     if (!left_ok) begin
                        res_load      = 1'b1;
                        res_in.status = ST_EDGE;
                     end else begin
                        ram_en     = 1'b1;
                        ram_addr   = gs_dec[ADDR_W-1:0];
                        wr_addr_in = ge_dec[ADDR_W-1:0];
                        gs_in      = gs_dec;
                        ge_in      = ge_dec;
                     end
                  end
                  OP_RIGHT: begin
                     if (!right_ok) begin
                        res_load      = 1'b1;
                        res_in.status = ST_EDGE;
                     end else begin
                        ram_en     = 1'b1;
                        ram_addr   = ge_ff[ADDR_W-1:0];
                        wr_addr_in = gs_ff[ADDR_W-1:0];
                        gs_in      = gs_inc;
                        ge_in      = ge_inc;
                     end
                  end
                  OP_BACK: begin
                     res_load = 1'b1;
                     if (!left_ok) begin
                        res_in.status = ST_EDGE;
                     end else begin
                        gs_in = gs_dec;
                     end
                  end
                  OP_READ: begin
                     if (!read_ok) begin
                        res_load      = 1'b1;
                        res_in.status = ST_RANGE;
                     end else begin
                        ram_en   = 1'b1;
                        ram_addr = read_idx[ADDR_W-1:0];
                     end
                  end
                  default: begin
                     res_load      = 1'b1;
                     res_in.status = ST_EDGE;
                  end
               endcase
            end
         end
         BK_MOVE: begin
            // The character read last cycle lands on the other side of the gap.
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = wr_addr_ff;
            ram_wdata = ram_rdata;
            res_load  = 1'b1;
         end
         BK_READ: begin
            res_load         = 1'b1;
            res_in.read_char = ram_rdata;
         end
         default: begin
         end
      endcase
      res_in.text_length = LEN_W'(len_next);
      res_in.cursor_pos  = LEN_W'(gs_in);
   end

   assign rsp_valid_in = res_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_EXEC;
         gs_ff        <= '0;
         ge_ff        <= PTR_W'(DEPTH);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gs_ff        <= gs_in;
         ge_ff        <= ge_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= wr_addr_in;
      if (res_load) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = res_ff;

endmodule

// ===== tb/cursor_line_editor_checker.sv =====
// Checker for the line editor: follows both word streams, predicts every reply and compares.
module cursor_line_editor_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   // ch [7:0], position [17:8], zero [23:18]
   input  logic [cle_pkg::REQ_TDATA_W-1:0] req_tdata,
   // cmd [2:0]
   input  logic [cle_pkg::REQ_TUSER_W-1:0] req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // read_char [7:0], text_length [18:8], cursor_pos [29:19], zero [31:30]
   input  logic [cle_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // status [1:0]
   input  logic [cle_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   input  logic                            drain_done,
   output int                              fail_count,
   output int                              replies_waiting,
   output int                              line_length,
   output int                              replies_checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import cle_pkg::*;

   localparam int MAX_PRINTED = 40;

   // Private copy of the gap buffer: left text in [0, gap_lo), right text in [gap_hi, DEPTH).
   logic [CH_W-1:0]  line_mem [DEPTH];
   logic [PTR_W-1:0] gap_lo;
   logic [PTR_W-1:0] gap_hi;
   result_type       replies_due [$];
   int               errors = 0;
   int               checked = 0;

   assign fail_count      = errors;
   assign replies_checked = checked;

   task automatic report_mismatch(input string what);
      if (errors < MAX_PRINTED)
         $display("[%0t] mismatch: %s", $time, what);
      errors++;
   endtask

   function automatic result_type edit_line(input logic [CMD_W-1:0] cmd,
                                            input logic [CH_W-1:0]  ch,
                                            input logic [POS_W-1:0] pos);
      result_type r;
      int         len;
      int         idx;
      r = '0;
      r.status = ST_DONE;
      len = int'(gap_lo) + DEPTH - int'(gap_hi);
      case (cmd)
         CMD_INSERT: begin
            if (gap_lo == gap_hi) begin
               r.status = ST_FULL;
            end else begin
               line_mem[int'(gap_lo)] = ch;
               gap_lo = gap_lo + PTR_W'(1);
            end
         end
         CMD_LEFT: begin
            if (gap_lo == '0) begin
               r.status = ST_EDGE;
            end else begin
               gap_hi = gap_hi - PTR_W'(1);
               gap_lo = gap_lo - PTR_W'(1);
               line_mem[int'(gap_hi)] = line_mem[int'(gap_lo)];
            end
         end
         CMD_RIGHT: begin
            if (int'(gap_hi) >= DEPTH) begin
               r.status = ST_EDGE;
            end else begin
               line_mem[int'(gap_lo)] = line_mem[int'(gap_hi)];
               gap_lo = gap_lo + PTR_W'(1);
               gap_hi = gap_hi + PTR_W'(1);
            end
         end
         CMD_BACK: begin
            if (gap_lo == '0)
               r.status = ST_EDGE;
            else
               gap_lo = gap_lo - PTR_W'(1);
         end
         CMD_READ: begin
            if (int'(pos) >= len) begin
               r.status = ST_RANGE;
            end else begin
               // Indexes past the cursor skip over the gap.
               idx = (int'(pos) < int'(gap_lo)) ? int'(pos)
                                                : int'(pos) + int'(gap_hi) - int'(gap_lo);
               r.read_char = line_mem[idx];
            end
         end
         default: r.status = ST_EDGE;
      endcase
      r.text_length = LEN_W'(int'(gap_lo) + DEPTH - int'(gap_hi));
      r.cursor_pos  = LEN_W'(gap_lo);
      return r;
   endfunction

   always @(posedge clock) begin
      result_type seen;
      result_type due;
      if (reset) begin
         gap_lo = '0;
         gap_hi = PTR_W'(DEPTH);
         replies_due.delete();
      end else begin
         if (req_tvalid === 1'b1 && req_tready === 1'b1)
            replies_due.push_back(edit_line(req_tuser[CMD_W-1:0], req_tdata[CH_W-1:0],
                                            req_tdata[CH_W+POS_W-1:CH_W]));
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            seen.read_char   = rsp_tdata[CH_W-1:0];
            seen.text_length = rsp_tdata[CH_W+LEN_W-1:CH_W];
            seen.cursor_pos  = rsp_tdata[CH_W+2*LEN_W-1:CH_W+LEN_W];
            seen.status      = status_type'(rsp_tuser[STATUS_W-1:0]);
            if (replies_due.size() == 0) begin
               report_mismatch("reply word arrived with no command outstanding");
            end else begin
               due = replies_due.pop_front();
               checked++;
               if (seen.read_char !== due.read_char)
                  report_mismatch($sformatf("read_char got %0d, wanted %0d",
                                            seen.read_char, due.read_char));
               if (seen.text_length !== due.text_length)
                  report_mismatch($sformatf("text_length got %0d, wanted %0d",
                                            seen.text_length, due.text_length));
               if (seen.cursor_pos !== due.cursor_pos)
                  report_mismatch($sformatf("cursor_pos got %0d, wanted %0d",
                                            seen.cursor_pos, due.cursor_pos));
               if (seen.status !== due.status)
                  report_mismatch($sformatf("status got %0d, wanted %0d",
                                            seen.status, due.status));
            end
         end
      end
      replies_waiting <= replies_due.size();
      line_length     <= int'(gap_lo) + DEPTH - int'(gap_hi);
   end

   always @(posedge drain_done) begin
      if (replies_due.size() != 0)
         report_mismatch($sformatf("%0d replies never arrived", replies_due.size()));
   end

endmodule

// ===== tb/tb_cursor_line_editor.sv =====
// Testbench top for the line editor: clock, reset, command stimulus, stalls and the verdict.
module tb_cursor_line_editor;
   timeunit 1ns;
   timeprecision 1ps;
   import cle_pkg::*;

   localparam int CYCLE_LIMIT      = 300000;
   localparam int TAIL_CYCLES      = 10;
   localparam int RANDOM_PER_PHASE = 50;
   localparam int TRIM_COUNT       = 64;
   localparam int MIX_SPAN         = 16;
   localparam int CMD_CODES        = 1 << CMD_W;

   typedef enum int {
      MIX_GROW,
      MIX_SHRINK,
      MIX_WANDER
   } mix_type;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   drain_done = 1'b0;

   int fail_count;
   int replies_waiting;
   int line_length;
   int replies_checked;
   int cycle_count = 0;
   int idle_pct    = 0;
   int stall_pct   = 0;
   int sent_by_cmd [CMD_CODES];

   cursor_line_editor u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   cursor_line_editor_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .drain_done      (drain_done),
      .fail_count      (fail_count),
      .replies_waiting (replies_waiting),
      .line_length     (line_length),
      .replies_checked (replies_checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // Offers one command word, holds it until taken, then idles at random.
   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [CH_W-1:0] ch,
                            input logic [POS_W-1:0] pos);
      req_tvalid <= 1'b1;
      req_tuser  <= REQ_TUSER_W'(cmd);
      req_tdata  <= {{(REQ_TDATA_W-POS_W-CH_W){1'b0}}, pos, ch};
      do @(posedge clock); while (req_tready !== 1'b1);
      sent_by_cmd[cmd]++;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
   endtask

   function automatic logic [CMD_W-1:0] pick_cmd(input mix_type mix);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 3)
         return CMD_W'($urandom_range(int'(CMD_READ) + 1, CMD_CODES - 1));
      case (mix)
         MIX_GROW:   return (roll < 55) ? CMD_INSERT : (roll < 70) ? CMD_READ :
                            (roll < 80) ? CMD_LEFT : (roll < 90) ? CMD_RIGHT : CMD_BACK;
         MIX_SHRINK: return (roll < 55) ? CMD_BACK : (roll < 70) ? CMD_READ :
                            (roll < 80) ? CMD_LEFT : (roll < 90) ? CMD_RIGHT : CMD_INSERT;
         default:    return (roll < 35) ? CMD_LEFT : (roll < 70) ? CMD_RIGHT :
                            (roll < 88) ? CMD_READ : (roll < 94) ? CMD_INSERT : CMD_BACK;
      endcase
   endfunction

   // Mostly indexes inside the text, the rest anywhere in the field's range.
   function automatic logic [POS_W-1:0] pick_pos();
      if (line_length > 0 && $urandom_range(0, 3) != 0)
         return POS_W'($urandom_range(0, line_length - 1));
      return POS_W'($urandom_range(0, (1 << POS_W) - 1));
   endfunction

   initial begin
      mix_type mix;
      mix = MIX_GROW;
      foreach (sent_by_cmd[c])
         sent_by_cmd[c] = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Empty text: every edge case, out-of-range reads, unused codes; then a short text.
      send_word(CMD_LEFT, 8'h00, '0);
      send_word(CMD_RIGHT, 8'hFF, '1);
      send_word(CMD_BACK, 8'h00, '0);
      send_word(CMD_READ, 8'h00, '0);
      send_word(CMD_READ, 8'h00, '1);
      for (int c = int'(CMD_READ) + 1; c < CMD_CODES; c++)
         send_word(CMD_W'(c), 8'hFF, '1);
      send_word(CMD_INSERT, 8'h00, '1);
      send_word(CMD_INSERT, 8'hFF, '0);
      send_word(CMD_INSERT, 8'hA5, '0);
      send_word(CMD_INSERT, 8'h5A, '0);
      for (int p = 0; p < 5; p++)
         send_word(CMD_READ, 8'h00, POS_W'(p));
      send_word(CMD_RIGHT, 8'h00, '0);
      send_word(CMD_LEFT, 8'h00, '0);
      send_word(CMD_LEFT, 8'h00, '0);
      send_word(CMD_INSERT, 8'h3C, '0);
      send_word(CMD_READ, 8'h00, POS_W'(2));
      send_word(CMD_BACK, 8'h00, '0);
      repeat (5) send_word(CMD_LEFT, 8'h00, '0);
      send_word(CMD_BACK, 8'h00, '0);

      // Fill the whole store; the last few inserts find it full.
      repeat (DEPTH) send_word(CMD_INSERT, CH_W'($urandom), POS_W'($urandom));
      repeat (8) send_word(CMD_READ, 8'h00, POS_W'($urandom));
      send_word(CMD_READ, 8'h00, '1);
      repeat (3) send_word(CMD_LEFT, 8'h00, '0);
      send_word(CMD_INSERT, 8'h77, '0);
      repeat (4) send_word(CMD_RIGHT, 8'h00, '0);
      repeat (TRIM_COUNT) send_word(CMD_BACK, CH_W'($urandom), POS_W'($urandom));

      // Random mix in four idling phases: none, sender, receiver, both.
      for (int phase = 0; phase < 4; phase++) begin
         idle_pct  = (phase == 1) ? 50 : (phase == 3) ? 27 : 0;
         stall_pct = (phase == 2) ? 50 : (phase == 3) ? 27 : 0;
         for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            if (i % MIX_SPAN == 0)
               mix = mix_type'($urandom_range(0, 2));
            send_word(pick_cmd(mix), CH_W'($urandom), pick_pos());
         end
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (replies_waiting != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      drain_done <= 1'b1;
      repeat (2) @(posedge clock);

      $display("Summary: %0d replies checked; insert %0d, left %0d, right %0d, backspace %0d,",
               replies_checked, sent_by_cmd[CMD_INSERT], sent_by_cmd[CMD_LEFT],
               sent_by_cmd[CMD_RIGHT], sent_by_cmd[CMD_BACK]);
      $display("         read %0d, unused codes %0d; store filled once, four idling phases.",
               sent_by_cmd[CMD_READ], sent_by_cmd[5] + sent_by_cmd[6] + sent_by_cmd[7]);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== cursor_line_editor.f =====
+incdir+rtl/core
rtl/core/cle_pkg.sv
rtl/core/cle_ram.sv
rtl/core/cle_front.sv
rtl/core/cle_fifo.sv
rtl/core/cle_back.sv
rtl/core/cursor_line_editor.sv
tb/cursor_line_editor_checker.sv
tb/tb_cursor_line_editor.sv
